// File: rtl/core/slt_pkg.sv
// Shared types, token kind codes and keyword tables for the script lexer.
package slt_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int KW_COUNT    = 8;
   localparam int KW_MAX_LEN  = 6;
   localparam int CLASS_BITS  = 4;
   localparam int KIND_BITS   = 5;

   localparam logic [7:0] CHAR_NUL = 8'h00;

   typedef enum logic [CLASS_BITS-1:0] {
      CLS_OTHER  = 4'd0,
      CLS_NUL    = 4'd1,
      CLS_DIGIT  = 4'd2,
      CLS_ALPHA  = 4'd3,
      CLS_QUOTE  = 4'd4,
      CLS_ASSIGN = 4'd5,
      CLS_BANG   = 4'd6,
      CLS_LT     = 4'd7,
      CLS_GT     = 4'd8,
      CLS_SINGLE = 4'd9
   } class_type;

   typedef enum logic [7:0] {
      MODE_IDLE   = 8'b0000_0001,
      MODE_NUM    = 8'b0000_0010,
      MODE_IDENT  = 8'b0000_0100,
      MODE_STR    = 8'b0000_1000,
      MODE_ASSIGN = 8'b0001_0000,
      MODE_BANG   = 8'b0010_0000,
      MODE_LT     = 8'b0100_0000,
      MODE_GT     = 8'b1000_0000
   } mode_type;

   localparam logic [KIND_BITS-1:0] KIND_NUMBER    = 5'd0;
   localparam logic [KIND_BITS-1:0] KIND_TRUE      = 5'd1;
   localparam logic [KIND_BITS-1:0] KIND_FALSE     = 5'd2;
   localparam logic [KIND_BITS-1:0] KIND_RETURN    = 5'd3;
   localparam logic [KIND_BITS-1:0] KIND_LET       = 5'd4;
   localparam logic [KIND_BITS-1:0] KIND_IF        = 5'd5;
   localparam logic [KIND_BITS-1:0] KIND_ELSE      = 5'd6;
   localparam logic [KIND_BITS-1:0] KIND_WHILE     = 5'd7;
   localparam logic [KIND_BITS-1:0] KIND_STRING    = 5'd8;
   localparam logic [KIND_BITS-1:0] KIND_PLUS      = 5'd9;
   localparam logic [KIND_BITS-1:0] KIND_MINUS     = 5'd10;
   localparam logic [KIND_BITS-1:0] KIND_DIV       = 5'd11;
   localparam logic [KIND_BITS-1:0] KIND_MUL       = 5'd12;
   localparam logic [KIND_BITS-1:0] KIND_POW       = 5'd13;
   localparam logic [KIND_BITS-1:0] KIND_IDENT     = 5'd14;
   localparam logic [KIND_BITS-1:0] KIND_ASSIGN    = 5'd15;
   localparam logic [KIND_BITS-1:0] KIND_EQUAL     = 5'd16;
   localparam logic [KIND_BITS-1:0] KIND_BANG      = 5'd17;
   localparam logic [KIND_BITS-1:0] KIND_NOT_EQUAL = 5'd18;
   localparam logic [KIND_BITS-1:0] KIND_LT        = 5'd19;
   localparam logic [KIND_BITS-1:0] KIND_GT        = 5'd20;
   localparam logic [KIND_BITS-1:0] KIND_LTE       = 5'd21;
   localparam logic [KIND_BITS-1:0] KIND_GTE       = 5'd22;
   localparam logic [KIND_BITS-1:0] KIND_LPAREN    = 5'd23;
   localparam logic [KIND_BITS-1:0] KIND_RPAREN    = 5'd24;
   localparam logic [KIND_BITS-1:0] KIND_LBRACE    = 5'd25;
   localparam logic [KIND_BITS-1:0] KIND_RBRACE    = 5'd26;
   localparam logic [KIND_BITS-1:0] KIND_SEMICOLON = 5'd27;
   localparam logic [KIND_BITS-1:0] KIND_COMMA     = 5'd28;
   localparam logic [KIND_BITS-1:0] KIND_FUNCTION  = 5'd29;
   localparam logic [KIND_BITS-1:0] KIND_EOF       = 5'd30;

   // let if else while return true false func
   localparam logic [7:0] KW_TEXT [0:KW_COUNT-1][0:KW_MAX_LEN-1] = '{
      '{"l", "e", "t", 8'h00, 8'h00, 8'h00},
      '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"e", "l", "s", "e", 8'h00, 8'h00},
      '{"w", "h", "i", "l", "e", 8'h00},
      '{"r", "e", "t", "u", "r", "n"},
      '{"t", "r", "u", "e", 8'h00, 8'h00},
      '{"f", "a", "l", "s", "e", 8'h00},
      '{"f", "u", "n", "c", 8'h00, 8'h00}
   };
   localparam logic [2:0] KW_LEN [0:KW_COUNT-1] = '{
      3'd3, 3'd2, 3'd4, 3'd5, 3'd6, 3'd4, 3'd5, 3'd4
   };
   localparam logic [KIND_BITS-1:0] KW_KIND [0:KW_COUNT-1] = '{
      KIND_LET, KIND_IF, KIND_ELSE, KIND_WHILE,
      KIND_RETURN, KIND_TRUE, KIND_FALSE, KIND_FUNCTION
   };

endpackage

// File: rtl/core/script_lexer_tokenizer_core.sv
// Top level of the streaming script lexer: front end, queue, token engine, output register.
//
// Source bytes enter on the req_ channel, one per transfer; byte 0 ends the input.
// Tokens leave on the rsp_ channel, one per transfer, as kind, start offset and
// length; last_of_run marks the final token caused by one byte.
// The front end classifies each byte and tags it with its offset, then writes it
// into a four-entry queue. The token engine takes one byte from the queue per
// cycle while it is not held by the output register, and drives the output register.
// Throughput: one byte per cycle while rsp_stall is low; a byte that closes one
// token and forms another (e.g. "a;" or end of input after a run) holds the engine
// until it has sent both tokens. A token passes through the queue and then the
// output register before it appears on the rsp_ ports; the second token of such
// a byte follows the first.
// When rsp_stall is high with a valid token, the output register holds it, the engine
// waits at its next token and the queue fills; req_stall rises only once the queue is full.
// Reset clears the queue, the offset counter and the scan state; no token is valid
// after reset.
module script_lexer_tokenizer_core import slt_pkg::*; #(
   parameter int OFFSET_BITS = 24,
   parameter int LENGTH_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_char_code,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [KIND_BITS-1:0]   rsp_token_kind,
   output logic [OFFSET_BITS-1:0] rsp_token_start,
   output logic [LENGTH_BITS-1:0] rsp_token_length,
   output logic                   rsp_last_of_run
);

   localparam int ITEM_BITS = CLASS_BITS + KIND_BITS + 8 + OFFSET_BITS;

   logic                   push, pop, full, not_empty, out_ready;
   class_type              front_class;
   logic [KIND_BITS-1:0]   front_kind;
   logic [7:0]             front_char;
   logic [OFFSET_BITS-1:0] front_offset;
   logic [ITEM_BITS-1:0]   head_data;

   logic                   tok_valid, tok_last;
   logic [KIND_BITS-1:0]   tok_kind;
   logic [OFFSET_BITS-1:0] tok_start;
   logic [LENGTH_BITS-1:0] tok_length;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [KIND_BITS-1:0]   kind_ff;
   logic [OFFSET_BITS-1:0] start_ff;
   logic [LENGTH_BITS-1:0] length_ff;
   logic                   last_ff;

   slt_front #(.OFFSET_BITS(OFFSET_BITS)) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_char_code (req_char_code),
      .queue_full    (full),
      .req_stall     (req_stall),
      .push          (push),
      .item_class    (front_class),
      .item_kind     (front_kind),
      .item_char     (front_char),
      .item_offset   (front_offset)
   );

   slt_queue #(.WIDTH(ITEM_BITS)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({front_class, front_kind, front_char, front_offset}),
      .pop       (pop),
      .full      (full),
      .not_empty (not_empty),
      .head_data (head_data)
   );

   slt_back #(.OFFSET_BITS(OFFSET_BITS), .LENGTH_BITS(LENGTH_BITS)) u_back (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (not_empty),
      .item_class  (class_type'(head_data[ITEM_BITS-1 -: CLASS_BITS])),
      .item_kind   (head_data[OFFSET_BITS+8 +: KIND_BITS]),
      .item_char   (head_data[OFFSET_BITS +: 8]),
      .item_offset (head_data[OFFSET_BITS-1:0]),
      .out_ready   (out_ready),
      .pop         (pop),
      .tok_valid   (tok_valid),
      .tok_kind    (tok_kind),
      .tok_start   (tok_start),
      .tok_length  (tok_length),
      .tok_last    (tok_last)
   );

   assign out_ready    = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = out_ready ? tok_valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && tok_valid) begin
         kind_ff   <= tok_kind;
         start_ff  <= tok_start;
         length_ff <= tok_length;
         last_ff   <= tok_last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_token_kind   = kind_ff;
   assign rsp_token_start  = start_ff;
   assign rsp_token_length = length_ff;
   assign rsp_last_of_run  = last_ff;

endmodule

// File: rtl/core/slt_front.sv
// Front end: byte classifier and source offset counter feeding the queue.
module slt_front import slt_pkg::*; #(
   parameter int OFFSET_BITS = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic [7:0]             req_char_code,
   input  logic                   queue_full,
   output logic                   req_stall,
   output logic                   push,
   output class_type              item_class,
   output logic [KIND_BITS-1:0]   item_kind,
   output logic [7:0]             item_char,
   output logic [OFFSET_BITS-1:0] item_offset
);

   logic [OFFSET_BITS-1:0] offset_ff, offset_in;

   assign req_stall   = queue_full;
   assign push        = req_valid && !queue_full;
   assign item_char   = req_char_code;
   assign item_offset = offset_ff;

   always_comb begin
      item_kind  = KIND_EOF;
      item_class = CLS_OTHER;
      unique case (req_char_code) inside
         CHAR_NUL:    item_class = CLS_NUL;
         ["0":"9"]:   item_class = CLS_DIGIT;
         ["a":"z"],
         ["A":"Z"]:   item_class = CLS_ALPHA;
         "\"":        item_class = CLS_QUOTE;
         "=":         item_class = CLS_ASSIGN;
         "!":         item_class = CLS_BANG;
         "<":         item_class = CLS_LT;
         ">":         item_class = CLS_GT;
         ";": begin item_class = CLS_SINGLE; item_kind = KIND_SEMICOLON; end
         ",": begin item_class = CLS_SINGLE; item_kind = KIND_COMMA;     end
         "+": begin item_class = CLS_SINGLE; item_kind = KIND_PLUS;      end
         "-": begin item_class = CLS_SINGLE; item_kind = KIND_MINUS;     end
         "/": begin item_class = CLS_SINGLE; item_kind = KIND_DIV;       end
         "*": begin item_class = CLS_SINGLE; item_kind = KIND_MUL;       end
         "^": begin item_class = CLS_SINGLE; item_kind = KIND_POW;       end
         "(": begin item_class = CLS_SINGLE; item_kind = KIND_LPAREN;    end
         ")": begin item_class = CLS_SINGLE; item_kind = KIND_RPAREN;    end
         "{": begin item_class = CLS_SINGLE; item_kind = KIND_LBRACE;    end
         "}": begin item_class = CLS_SINGLE; item_kind = KIND_RBRACE;    end
         default:     item_class = CLS_OTHER;
      endcase
   end

   // offset returns to zero after end of input
   always_comb begin
      offset_in = offset_ff;
      if (push) begin
         if (req_char_code == CHAR_NUL) begin
            offset_in = '0;
         end else begin
            offset_in = offset_ff + OFFSET_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
      end else begin
         offset_ff <= offset_in;
      end
   end

endmodule

// File: rtl/core/slt_queue.sv
// Small FIFO of classified bytes between front end and token engine.
module slt_queue import slt_pkg::*; #(
   parameter int WIDTH = 41
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic             full,
   output logic             not_empty,
   output logic [WIDTH-1:0] head_data
);

   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0]    mem [0:QUEUE_DEPTH-1];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;

   assign full      = (count_ff == CNT_BITS'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_data = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: rtl/core/slt_back.sv
// Token engine: scan state machine, keyword matcher and token sequencing.
module slt_back import slt_pkg::*; #(
   parameter int OFFSET_BITS = 24,
   parameter int LENGTH_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   item_valid,
   input  class_type              item_class,
   input  logic [KIND_BITS-1:0]   item_kind,
   input  logic [7:0]             item_char,
   input  logic [OFFSET_BITS-1:0] item_offset,
   input  logic                   out_ready,
   output logic                   pop,
   output logic                   tok_valid,
   output logic [KIND_BITS-1:0]   tok_kind,
   output logic [OFFSET_BITS-1:0] tok_start,
   output logic [LENGTH_BITS-1:0] tok_length,
   output logic                   tok_last
);

   localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;
   localparam logic [LENGTH_BITS-1:0] KW_SPAN = LENGTH_BITS'(KW_MAX_LEN);

   mode_type               mode_ff, mode_in;
   logic [OFFSET_BITS-1:0] start_ff, start_in;
   logic [LENGTH_BITS-1:0] length_ff, length_in;
   logic [KW_COUNT-1:0]    cand_ff, cand_in;
   logic                   phase_ff, phase_in;

   logic                   pre_valid, post_valid, done;
   logic [KIND_BITS-1:0]   pre_kind, post_kind, ident_kind;
   logic [OFFSET_BITS-1:0] post_start;
   logic [LENGTH_BITS-1:0] pre_length, post_length, grown;
   logic [KW_COUNT-1:0]    cand_next, cand_first;
   logic                   two_tokens, update;

   function automatic logic [KW_COUNT-1:0] kw_match(
      input logic [KW_COUNT-1:0]    cand,
      input logic [LENGTH_BITS-1:0] pos,
      input logic [7:0]             ch
   );
      logic [KW_COUNT-1:0] keep;
      keep = '0;
      for (int i = 0; i < KW_COUNT; i++) begin
         keep[i] = cand[i] && (pos < KW_SPAN) && (KW_TEXT[i][pos[2:0]] == ch);
      end
      return keep;
   endfunction

   assign grown      = (length_ff == LEN_MAX) ? length_ff : length_ff + LENGTH_BITS'(1);
   assign cand_next  = kw_match(cand_ff, length_ff, item_char);
   assign cand_first = kw_match('1, '0, item_char);

   // lowest keyword index wins
   always_comb begin
      ident_kind = KIND_IDENT;
      for (int i = KW_COUNT - 1; i >= 0; i--) begin
         if (cand_ff[i] && (length_ff == {{(LENGTH_BITS-3){1'b0}}, KW_LEN[i]})) begin
            ident_kind = KW_KIND[i];
         end
      end
   end

   always_comb begin
      mode_in     = mode_ff;
      start_in    = start_ff;
      length_in   = length_ff;
      cand_in     = cand_ff;
      pre_valid   = 1'b0;
      pre_kind    = KIND_STRING;
      pre_length  = length_ff;
      done        = 1'b0;
      post_valid  = 1'b0;
      post_kind   = item_kind;
      post_start  = item_offset;
      post_length = LENGTH_BITS'(1);

      unique case (mode_ff) inside
         MODE_STR: begin
            if (item_class == CLS_QUOTE) begin
               pre_valid = 1'b1;
               mode_in   = MODE_IDLE;
               done      = 1'b1;
            end else if (item_class != CLS_NUL) begin
               length_in = grown;
               done      = 1'b1;
            end else begin
               pre_valid = 1'b1;
               mode_in   = MODE_IDLE;
            end
         end
         MODE_NUM: begin
            if (item_class == CLS_DIGIT) begin
               length_in = grown;
               done      = 1'b1;
            end else begin
               pre_valid = 1'b1;
               pre_kind  = KIND_NUMBER;
               mode_in   = MODE_IDLE;
            end
         end
         MODE_IDENT: begin
            if (item_class == CLS_ALPHA) begin
               cand_in   = cand_next;
               length_in = grown;
               done      = 1'b1;
            end else begin
               pre_valid = 1'b1;
               pre_kind  = ident_kind;
               mode_in   = MODE_IDLE;
            end
         end
         MODE_ASSIGN, MODE_BANG, MODE_LT, MODE_GT: begin
            pre_valid = 1'b1;
            mode_in   = MODE_IDLE;
            done      = (item_class == CLS_ASSIGN);
            pre_length = done ? LENGTH_BITS'(2) : LENGTH_BITS'(1);
            unique case (mode_ff)
               MODE_ASSIGN: pre_kind = done ? KIND_EQUAL     : KIND_ASSIGN;
               MODE_BANG:   pre_kind = done ? KIND_NOT_EQUAL : KIND_BANG;
               MODE_LT:     pre_kind = done ? KIND_LTE       : KIND_LT;
               default:     pre_kind = done ? KIND_GTE       : KIND_GT;
            endcase
         end
         default: ;
      endcase

      if (!done) begin
         unique case (item_class)
            CLS_NUL: begin
               post_valid  = 1'b1;
               post_kind   = KIND_EOF;
               post_length = '0;
               mode_in     = MODE_IDLE;
               start_in    = '0;
               length_in   = '0;
               cand_in     = '1;
            end
            CLS_SINGLE: begin
               post_valid = 1'b1;
            end
            CLS_ASSIGN: begin
               mode_in  = MODE_ASSIGN;
               start_in = item_offset;
            end
            CLS_BANG: begin
               mode_in  = MODE_BANG;
               start_in = item_offset;
            end
            CLS_LT: begin
               mode_in  = MODE_LT;
               start_in = item_offset;
            end
            CLS_GT: begin
               mode_in  = MODE_GT;
               start_in = item_offset;
            end
            CLS_QUOTE: begin
               mode_in   = MODE_STR;
               start_in  = item_offset + OFFSET_BITS'(1);
               length_in = '0;
            end
            CLS_DIGIT: begin
               mode_in   = MODE_NUM;
               start_in  = item_offset;
               length_in = LENGTH_BITS'(1);
            end
            CLS_ALPHA: begin
               mode_in   = MODE_IDENT;
               start_in  = item_offset;
               length_in = LENGTH_BITS'(1);
               cand_in   = cand_first;
            end
            default: ;
         endcase
      end
   end

   // two tokens from one byte go out one after the other; state moves on the last one
   assign two_tokens = pre_valid && post_valid;
   assign tok_valid  = item_valid && (pre_valid || post_valid);
   assign update     = item_valid && (!tok_valid || (out_ready && (!two_tokens || phase_ff)));
   assign pop        = update;

   always_comb begin
      if (pre_valid && !(two_tokens && phase_ff)) begin
         tok_kind   = pre_kind;
         tok_start  = start_ff;
         tok_length = pre_length;
         tok_last   = !two_tokens;
      end else begin
         tok_kind   = post_kind;
         tok_start  = post_start;
         tok_length = post_length;
         tok_last   = 1'b1;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      if (item_valid && out_ready && two_tokens) begin
         phase_in = !phase_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         start_ff  <= '0;
         length_ff <= '0;
         cand_ff   <= '1;
         phase_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         if (update) begin
            mode_ff   <= mode_in;
            start_ff  <= start_in;
            length_ff <= length_in;
            cand_ff   <= cand_in;
         end
      end
   end

endmodule

// File: rtl/core/slt_checker.sv
// Port-level checks for the script lexer and their binding to the top level.
module slt_checker import slt_pkg::*; #(
   parameter int OFFSET_BITS = 24,
   parameter int LENGTH_BITS = 16
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input logic [KIND_BITS-1:0]   rsp_token_kind,
   input logic [OFFSET_BITS-1:0] rsp_token_start,
   input logic [LENGTH_BITS-1:0] rsp_token_length,
   input logic                   rsp_last_of_run
);

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("token valid right after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_token_kind)
         && $stable(rsp_token_start) && $stable(rsp_token_length)
         && $stable(rsp_last_of_run))
      else $error("stalled token changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_token_kind == KIND_EOF) |-> (rsp_token_length == '0) && rsp_last_of_run)
      else $error("end of input token malformed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_token_kind == KIND_EQUAL || rsp_token_kind == KIND_NOT_EQUAL
         || rsp_token_kind == KIND_LTE || rsp_token_kind == KIND_GTE)
      |-> (rsp_token_length == LENGTH_BITS'(2)) && rsp_last_of_run)
      else $error("two-character operator length wrong");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_token_kind == KIND_ASSIGN || rsp_token_kind == KIND_BANG
         || rsp_token_kind == KIND_LT || rsp_token_kind == KIND_GT
         || rsp_token_kind == KIND_SEMICOLON || rsp_token_kind == KIND_PLUS)
      |-> (rsp_token_length == LENGTH_BITS'(1)))
      else $error("single-character operator length wrong");

endmodule

bind script_lexer_tokenizer_core slt_checker #(
   .OFFSET_BITS (OFFSET_BITS),
   .LENGTH_BITS (LENGTH_BITS)
) u_slt_checker (.*);

// File: dv/script_lexer_tokenizer_core_tb.sv
// Self-checking testbench for the script lexer core: directed table, random token streams.
module script_lexer_tokenizer_core_tb;
   import slt_pkg::*;

   localparam int OFF_W = 24;
   localparam int LEN_W = 16;

   typedef struct packed {
      logic [KIND_BITS-1:0] kind;
      logic [OFF_W-1:0]     start;
      logic [LEN_W-1:0]     len;
      logic                 last;
   } token_type;

   typedef struct packed {
      logic [7:0]           ch;
      logic                 typed;
      logic [KIND_BITS-1:0] kind;
      logic [OFF_W-1:0]     start;
      logic [LEN_W-1:0]     len;
   } script_row_type;

   // typed rows cause exactly one token
   localparam script_row_type OPENING_ROWS [24] = '{
      '{";",   1'b1, KIND_SEMICOLON, 24'd0,  16'd1},
      '{"+",   1'b1, KIND_PLUS,      24'd1,  16'd1},
      '{"-",   1'b1, KIND_MINUS,     24'd2,  16'd1},
      '{"/",   1'b1, KIND_DIV,       24'd3,  16'd1},
      '{"*",   1'b1, KIND_MUL,       24'd4,  16'd1},
      '{"^",   1'b1, KIND_POW,       24'd5,  16'd1},
      '{"(",   1'b1, KIND_LPAREN,    24'd6,  16'd1},
      '{")",   1'b1, KIND_RPAREN,    24'd7,  16'd1},
      '{"{",   1'b1, KIND_LBRACE,    24'd8,  16'd1},
      '{"}",   1'b1, KIND_RBRACE,    24'd9,  16'd1},
      '{",",   1'b1, KIND_COMMA,     24'd10, 16'd1},
      '{ch: "=", default: '0},
      '{"=",   1'b1, KIND_EQUAL,     24'd11, 16'd2},
      '{ch: "!", default: '0},
      '{"x",   1'b1, KIND_BANG,      24'd13, 16'd1},
      '{"9",   1'b1, KIND_IDENT,     24'd14, 16'd1},
      '{"<",   1'b1, KIND_NUMBER,    24'd15, 16'd1},
      '{"=",   1'b1, KIND_LTE,       24'd16, 16'd2},
      '{ch: ">", default: '0},
      '{8'hFF, 1'b1, KIND_GT,        24'd18, 16'd1},
      '{ch: "\"", default: '0},
      '{ch: 8'h80, default: '0},
      '{ch: CHAR_NUL, default: '0},
      '{CHAR_NUL, 1'b1, KIND_EOF,    24'd0,  16'd0}
   };

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [7:0]             req_char_code = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [KIND_BITS-1:0]   rsp_token_kind;
   logic [OFF_W-1:0]       rsp_token_start;
   logic [LEN_W-1:0]       rsp_token_length;
   logic                   rsp_last_of_run;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int bytes_sent = 0;
   int mismatch_count = 0;

   token_type expected_tokens [$];
   token_type lex_out [$];

   mode_type         lex_mode;
   logic [OFF_W-1:0] lex_offset;
   logic [OFF_W-1:0] lex_start;
   logic [LEN_W-1:0] lex_len;
   logic [7:0]       kw_alive;

   string kw_word [8] = '{"let", "if", "else", "while", "return", "true", "false", "func"};
   logic [KIND_BITS-1:0] kw_kind [8] = '{KIND_LET, KIND_IF, KIND_ELSE, KIND_WHILE,
                                         KIND_RETURN, KIND_TRUE, KIND_FALSE, KIND_FUNCTION};
   string op_chars = "+-*/^(){};,=!<>";

   script_lexer_tokenizer_core #(
      .OFFSET_BITS(OFF_W),
      .LENGTH_BITS(LEN_W)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_char_code(req_char_code),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_token_kind(rsp_token_kind),
      .rsp_token_start(rsp_token_start),
      .rsp_token_length(rsp_token_length),
      .rsp_last_of_run(rsp_last_of_run)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void clear_lexer();
      lex_mode   = MODE_IDLE;
      lex_offset = '0;
      lex_start  = '0;
      lex_len    = '0;
      kw_alive   = 8'hFF;
   endfunction

   function automatic logic is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_alpha(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic void add_token(logic [KIND_BITS-1:0] kind, logic [OFF_W-1:0] start,
                                     logic [LEN_W-1:0] len);
      lex_out.insert(lex_out.size(), token_type'{kind, start, len, 1'b0});
   endfunction

   function automatic void grow_run();
      if (lex_len != '1) lex_len++;
   endfunction

   function automatic void match_letter(logic [7:0] c);
      for (int i = 0; i < 8; i++) begin
         if (lex_len >= kw_word[i].len() || kw_word[i][lex_len] != c) kw_alive[i] = 1'b0;
      end
   endfunction

   function automatic logic [KIND_BITS-1:0] word_kind();
      for (int i = 0; i < 8; i++) begin
         if (kw_alive[i] && lex_len == kw_word[i].len()) return kw_kind[i];
      end
      return KIND_IDENT;
   endfunction

   // pending = ! < > resolved by the next byte; returns 1 when that byte is consumed
   function automatic logic close_op(logic [7:0] c, logic [KIND_BITS-1:0] pair_kind,
                                     logic [KIND_BITS-1:0] single_kind);
      lex_mode = MODE_IDLE;
      if (c == "=") begin
         add_token(pair_kind, lex_start, 16'd2);
         return 1'b1;
      end
      add_token(single_kind, lex_start, 16'd1);
      return 1'b0;
   endfunction

   function automatic void open_op(mode_type m);
      lex_mode  = m;
      lex_start = lex_offset;
   endfunction

   function automatic void lex_byte(logic [7:0] c);
      logic taken;
      taken = 1'b0;
      lex_out.delete();
      case (lex_mode)
         MODE_STR: begin
            if (c == "\"") begin
               add_token(KIND_STRING, lex_start, lex_len);
               lex_mode = MODE_IDLE;
               taken = 1'b1;
            end else if (c != CHAR_NUL) begin
               grow_run();
               taken = 1'b1;
            end else begin
               add_token(KIND_STRING, lex_start, lex_len);
               lex_mode = MODE_IDLE;
            end
         end
         MODE_NUM: begin
            if (is_digit(c)) begin
               grow_run();
               taken = 1'b1;
            end else begin
               add_token(KIND_NUMBER, lex_start, lex_len);
               lex_mode = MODE_IDLE;
            end
         end
         MODE_IDENT: begin
            if (is_alpha(c)) begin
               match_letter(c);
               grow_run();
               taken = 1'b1;
            end else begin
               add_token(word_kind(), lex_start, lex_len);
               lex_mode = MODE_IDLE;
            end
         end
         MODE_ASSIGN: taken = close_op(c, KIND_EQUAL, KIND_ASSIGN);
         MODE_BANG:   taken = close_op(c, KIND_NOT_EQUAL, KIND_BANG);
         MODE_LT:     taken = close_op(c, KIND_LTE, KIND_LT);
         MODE_GT:     taken = close_op(c, KIND_GTE, KIND_GT);
         default: ;
      endcase
      if (!taken) begin
         case (c)
            CHAR_NUL: add_token(KIND_EOF, lex_offset, 16'd0);
            ";": add_token(KIND_SEMICOLON, lex_offset, 16'd1);
            ",": add_token(KIND_COMMA, lex_offset, 16'd1);
            "+": add_token(KIND_PLUS, lex_offset, 16'd1);
            "-": add_token(KIND_MINUS, lex_offset, 16'd1);
            "/": add_token(KIND_DIV, lex_offset, 16'd1);
            "*": add_token(KIND_MUL, lex_offset, 16'd1);
            "^": add_token(KIND_POW, lex_offset, 16'd1);
            "(": add_token(KIND_LPAREN, lex_offset, 16'd1);
            ")": add_token(KIND_RPAREN, lex_offset, 16'd1);
            "{": add_token(KIND_LBRACE, lex_offset, 16'd1);
            "}": add_token(KIND_RBRACE, lex_offset, 16'd1);
            "=": open_op(MODE_ASSIGN);
            "!": open_op(MODE_BANG);
            "<": open_op(MODE_LT);
            ">": open_op(MODE_GT);
            "\"": begin
               lex_mode  = MODE_STR;
               lex_start = lex_offset + 1'b1;
               lex_len   = '0;
            end
            default: begin
               if (is_digit(c)) begin
                  lex_mode  = MODE_NUM;
                  lex_start = lex_offset;
                  lex_len   = 16'd1;
               end else if (is_alpha(c)) begin
                  lex_mode  = MODE_IDENT;
                  lex_start = lex_offset;
                  lex_len   = '0;
                  kw_alive  = 8'hFF;
                  match_letter(c);
                  lex_len   = 16'd1;
               end
            end
         endcase
      end
      if (!taken && c == CHAR_NUL) clear_lexer();
      else lex_offset++;
      if (lex_out.size() != 0) lex_out[lex_out.size()-1].last = 1'b1;
   endfunction

   task automatic push_byte(input logic [7:0] b, input logic typed = 1'b0,
                            input token_type want = '0);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_char_code <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      lex_byte(b);
      bytes_sent++;
      if (typed) expected_tokens.insert(expected_tokens.size(), want);
      else foreach (lex_out[i]) expected_tokens.insert(expected_tokens.size(), lex_out[i]);
   endtask

   function automatic logic [7:0] rand_letter();
      return 8'(($urandom_range(3) == 0 ? 8'h41 : 8'h61) + $urandom_range(25));
   endfunction

   task automatic send_lexeme();
      int pick;
      int n;
      int k;
      string w;
      logic [7:0] b;
      pick = $urandom_range(99);
      if (pick < 8) begin
         push_byte(8'($urandom_range(255)));
      end else if (pick < 26) begin
         // keyword, sometimes with a case flip, an extra letter or a missing letter
         w = kw_word[$urandom_range(7)];
         k = $urandom_range(7);
         n = (k == 2) ? w.len() - 1 : w.len();
         for (int i = 0; i < n; i++) begin
            b = w[i];
            if (k == 0 && i == 0) b = b ^ 8'h20;
            push_byte(b);
         end
         if (k == 1) push_byte(rand_letter());
      end else if (pick < 40) begin
         repeat ($urandom_range(1, 8)) push_byte(rand_letter());
      end else if (pick < 54) begin
         repeat ($urandom_range(1, 6)) push_byte(8'(8'h30 + $urandom_range(9)));
      end else if (pick < 64) begin
         push_byte("\"");
         repeat ($urandom_range(0, 8)) begin
            do b = 8'($urandom_range(1, 255)); while (b == "\"");
            push_byte(b);
         end
         if ($urandom_range(9) == 0) push_byte(CHAR_NUL);
         else push_byte("\"");
      end else if (pick < 84) begin
         b = op_chars[$urandom_range(14)];
         push_byte(b);
         if ((b == "=" || b == "!" || b == "<" || b == ">") && $urandom_range(1))
            push_byte("=");
      end else if (pick < 97) begin
         case ($urandom_range(3))
            0: push_byte(" ");
            1: push_byte(8'h09);
            2: push_byte(8'h0A);
            default: push_byte(8'($urandom_range(128, 255)));
         endcase
      end else begin
         push_byte(CHAR_NUL);
      end
      if ($urandom_range(4) < 2) push_byte(" ");
   endtask

   task automatic run_phase(input int s_pct, input int r_pct, input int budget);
      int stop_at;
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      stop_at = bytes_sent + budget;
      while (bytes_sent < stop_at) send_lexeme();
   endtask

   function automatic void check_field(string what, longint unsigned want,
                                       longint unsigned got);
      if (want != got) begin
         $display("%0t: %s expected %0d got %0d", $time, what, want, got);
         mismatch_count++;
      end
   endfunction

   function automatic void check_token(token_type got);
      token_type want;
      if (expected_tokens.size() == 0) begin
         $display("%0t: token expected none got kind %0d start %0d length %0d last %0d",
                  $time, got.kind, got.start, got.len, got.last);
         mismatch_count++;
         return;
      end
      want = expected_tokens.pop_front();
      check_field("token_kind", want.kind, got.kind);
      check_field("token_start", want.start, got.start);
      check_field("token_length", want.len, got.len);
      check_field("last_of_run", want.last, got.last);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall)
            check_token(token_type'{rsp_token_kind, rsp_token_start, rsp_token_length,
                                    rsp_last_of_run});
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   initial begin
      clear_lexer();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < $size(OPENING_ROWS); i++)
         push_byte(OPENING_ROWS[i].ch, OPENING_ROWS[i].typed,
                   token_type'{OPENING_ROWS[i].kind, OPENING_ROWS[i].start,
                               OPENING_ROWS[i].len, 1'b1});

      run_phase(29, 74, 300);
      run_phase(74, 29, 300);
      run_phase(0, 0, 300);

      run_phase(0, 0, 20);
      push_byte(CHAR_NUL);
      req_valid <= 1'b0;

      while (expected_tokens.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && expected_tokens.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
